[src/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer: item kinds,
// field widths, the controller state type and a saturating counter helper.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Field widths of the input and result items.
    localparam int KIND_W    = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_IN_W  = 6;
    localparam int BYTE_W    = 8;
    localparam int NBITS_W   = 4;
    localparam int TOTAL_W   = 32;

    // Code table geometry and the default longest code.
    localparam int TBL_DEPTH         = 256;
    localparam int DEF_MAX_CODE_LEN  = 32;

    // Item kinds; the fourth code is ignored.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_EMIT   = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    // Adds a small bit count to the running total, sticking at all ones.
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [NBITS_W-1:0] n);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W+1)'(n);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

[src/hcbp_ram.sv]
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: either a write or a registered read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/huffman_code_bit_packer_top.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Huffman code bit packer: code table load, symbol encode into bytes with the
// first code bit in bit 7, and end-of-stream flush with a running bit total.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one item: a load of a code
//   table entry, an encode of a symbol, or a flush. Output channel
//   (o_valid / i_stall) carries packed bytes; o_last marks the final byte
//   caused by an item.
//   Work per item:
//     load or unused kind: taken in S_IDLE with no further state.
//     encode: k = 0..4 bytes produced (a table read, then S_LOOKUP, then
//             one byte per cycle in S_EMIT through the single output
//             register while the receiver does not stall).
//     flush:  S_FLUSH loads one byte into the output register.
//   One item is worked on at a time. An encode's first byte passes the
//   RAM read register, S_LOOKUP and S_EMIT before it reaches o_valid;
//   a flush byte is loaded from S_FLUSH into the output register.
//   A finished byte sits in the output register while a new item is taken.
//   When the receiver stalls, byte production waits and o_stall stays high.
//   Reset clears the controller, the pending bits, the total and the
//   per-entry valid flags, so every table entry reads as length zero with
//   no clearing pass.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [CODE_W-1:0]   i_code_bits,
    input  logic [LEN_IN_W-1:0] i_code_len,
    // result item channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic [NBITS_W-1:0]  o_bits_in_byte,
    output logic [TOTAL_W-1:0]  o_total_bits,
    output logic                o_last
);

    // Stored code width, length width, accumulator and counter widths.
    localparam int LIM   = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam int LW    = $clog2(LIM + 1);
    localparam int ENT_W = LW + LIM;
    localparam int ACC_W = BYTE_W + LIM;
    localparam int CW    = $clog2(ACC_W + 1);
    localparam int AW    = $clog2(TBL_DEPTH);

    t_state               r_state, n_state;
    logic [TBL_DEPTH-1:0] r_tbl_vld;
    logic                 r_hit;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [BYTE_W-1:0]    r_pend_bits, n_pend_bits;
    logic [NBITS_W-1:0]   r_pend_cnt, n_pend_cnt;
    logic [TOTAL_W-1:0]   r_total, n_total;

    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic [NBITS_W-1:0]   r_out_nbits, n_out_nbits;
    logic [TOTAL_W-1:0]   r_out_total, n_out_total;
    logic                 r_out_last, n_out_last;
    logic                 w_out_load;

    logic                 w_in_acc;
    logic                 w_is_load;
    logic                 w_is_enc;
    logic [LW-1:0]        w_ld_len;
    logic [LIM-1:0]       w_ld_bits;
    logic [ENT_W-1:0]     w_rdata;
    logic [LW-1:0]        w_lk_len;
    logic [LIM-1:0]       w_lk_bits;
    logic [ACC_W-1:0]     w_lk_acc;
    logic [CW-1:0]        w_lk_cnt;
    logic [ACC_W-1:0]     w_emit_sh;
    logic [CW-1:0]        w_emit_rem;
    logic                 w_emit_last;
    logic [BYTE_W-1:0]    w_rem_mask;
    logic                 w_out_free;

    // Input handshake: one item at a time.
    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && (r_state == S_IDLE);
    assign w_is_load = (i_kind == KIND_LOAD);
    assign w_is_enc  = (i_kind == KIND_ENCODE);

    // Load path: saturate the length and drop code bits above it.
    always_comb begin
        w_ld_len = (i_code_len > LEN_IN_W'(LIM)) ? LW'(LIM) : i_code_len[LW-1:0];
        for (int k = 0; k < LIM; k++) begin
            w_ld_bits[k] = i_code_bits[k] && (LW'(k) < w_ld_len);
        end
    end

    // Code table storage: {length, code bits} per symbol.
    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TBL_DEPTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_en    (w_in_acc && (w_is_load || w_is_enc)),
        .i_we    (w_is_load),
        .i_addr  (i_symbol[AW-1:0]),
        .i_wdata ({w_ld_len, w_ld_bits}),
        .o_rdata (w_rdata)
    );

    // Lookup: an entry never loaded since reset reads as length zero.
    assign w_lk_len  = r_hit ? w_rdata[ENT_W-1:LIM] : '0;
    assign w_lk_bits = r_hit ? w_rdata[LIM-1:0] : '0;
    assign w_lk_acc  = (ACC_W'(r_pend_bits) << w_lk_len) | ACC_W'(w_lk_bits);
    assign w_lk_cnt  = CW'(r_pend_cnt) + CW'(w_lk_len);

    // Byte extraction from the top of the significant accumulator bits.
    assign w_emit_sh   = r_acc >> (r_cnt - CW'(BYTE_W));
    assign w_emit_rem  = r_cnt - CW'(BYTE_W);
    assign w_emit_last = (w_emit_rem <= CW'(BYTE_W));
    assign w_rem_mask  = {BYTE_W{1'b1}} >> (NBITS_W'(BYTE_W) - w_emit_rem[NBITS_W-1:0]);

    // The output register can take a byte when empty or being drained.
    assign w_out_free = !r_out_valid || !i_stall;

    // Controller and pending bit state.
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_total     = r_total;
        w_out_load  = 1'b0;
        n_out_byte  = r_out_byte;
        n_out_nbits = r_out_nbits;
        n_out_total = r_out_total;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_enc) begin
                        n_state = S_LOOKUP;
                    end else if (i_kind == KIND_FLUSH) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_LOOKUP: begin
                n_acc = w_lk_acc;
                n_cnt = w_lk_cnt;
                if (w_lk_cnt > CW'(BYTE_W)) begin
                    n_state = S_EMIT;
                end else begin
                    n_pend_bits = w_lk_acc[BYTE_W-1:0];
                    n_pend_cnt  = w_lk_cnt[NBITS_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_total     = sat_add(r_total, NBITS_W'(BYTE_W));
                    n_out_byte  = w_emit_sh[BYTE_W-1:0];
                    n_out_nbits = NBITS_W'(BYTE_W);
                    n_out_total = n_total;
                    n_out_last  = w_emit_last;
                    n_cnt       = w_emit_rem;
                    if (w_emit_last) begin
                        n_pend_bits = r_acc[BYTE_W-1:0] & w_rem_mask;
                        n_pend_cnt  = w_emit_rem[NBITS_W-1:0];
                        n_state     = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out_byte  = r_pend_bits << (NBITS_W'(BYTE_W) - r_pend_cnt);
                    n_out_nbits = r_pend_cnt;
                    n_out_total = sat_add(r_total, r_pend_cnt);
                    n_out_last  = 1'b1;
                    n_pend_bits = '0;
                    n_pend_cnt  = '0;
                    n_total     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and entry valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tbl_vld   <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_total     <= n_total;
            if (w_in_acc && w_is_load) begin
                r_tbl_vld[i_symbol[AW-1:0]] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_cnt       <= n_cnt;
        r_out_byte  <= n_out_byte;
        r_out_nbits <= n_out_nbits;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
        if (w_in_acc && w_is_enc) begin
            r_hit <= r_tbl_vld[i_symbol[AW-1:0]];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_bits_in_byte = r_out_nbits;
    assign o_total_bits   = r_out_total;
    assign o_last         = r_out_last;

    // The pending buffer never holds more than one byte.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= NBITS_W'(BYTE_W))
        else $error("pending count exceeds one byte");

    // The emit state is only entered while more than one byte is held.
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt > CW'(BYTE_W)))
        else $error("emit state entered without a full byte");

    // A partial byte only comes from a flush, which is always the last result.
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_bits_in_byte != NBITS_W'(BYTE_W))) |-> o_last)
        else $error("partial byte without last flag");

    // After a flush result is produced the stream state is cleared.
    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && w_out_free) |=> ((r_pend_cnt == '0) && (r_total == '0)))
        else $error("flush did not clear the stream state");

endmodule
